// ===== rtl/sdq_pkg.sv =====
// ----------------------------------------------------------------------------
// sdq_pkg
// Command and status codes and the per-cell control bundle shared by the
// sorted priority deque, its cells and its checker.
// ----------------------------------------------------------------------------
package sdq_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int PRIO_PORT_WIDTH = 8;
   localparam int COUNT_PORT_WIDTH = 5;

   typedef enum logic [1:0] {
      CMD_INSERT    = 2'd0,
      CMD_TAKE_HEAD = 2'd1,
      CMD_TAKE_TAIL = 2'd2,
      CMD_TAKE_PRIO = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   // At most one field is set; each is already qualified by full/empty/found.
   typedef struct packed {
      logic insert;
      logic take_head;
      logic take_tail;
      logic take_prio;
   } cell_ctrl_type;

endpackage

// ===== rtl/sorted_priority_deque.sv =====
// ----------------------------------------------------------------------------
// sorted_priority_deque
// Bounded double-ended priority queue kept sorted by descending priority in a
// row of compare-and-shift cells; equal priorities keep arrival order.
// ----------------------------------------------------------------------------
// Results: the result strobe rises in the cycle after the command is accepted.
// Throughput: one command per cycle; every cell compares and shifts in the
// same cycle, so busy stays low.
// Reset: synchronous; clears every slot's valid bit and the count directly,
// with no clearing pass. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sorted_priority_deque #(
   parameter int DEPTH          = 16,
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [1:0]                            req_command,
   input  logic signed [sdq_pkg::VALUE_WIDTH-1:0] req_item_value,
   input  logic [sdq_pkg::PRIO_PORT_WIDTH-1:0]   req_item_priority,
   output logic                                  rsp_strobe,
   output logic [1:0]                            rsp_status,
   output logic signed [sdq_pkg::VALUE_WIDTH-1:0] rsp_removed_value,
   output logic [sdq_pkg::PRIO_PORT_WIDTH-1:0]   rsp_removed_priority,
   output logic [sdq_pkg::COUNT_PORT_WIDTH-1:0]  rsp_entry_count,
   output logic                                  rsp_is_empty
);
   import sdq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);

   logic                      accept;
   command_type               cmd;
   logic [PRIORITY_WIDTH-1:0] key_prio;
   logic [VALUE_WIDTH-1:0]    key_value;
   cell_ctrl_type             ctrl;

   logic                      cell_valid [DEPTH];
   logic [VALUE_WIDTH-1:0]    cell_value [DEPTH];
   logic [PRIORITY_WIDTH-1:0] cell_prio  [DEPTH];
   logic                      cell_ge    [DEPTH];
   logic                      cell_eq    [DEPTH];
   logic                      cell_sel   [DEPTH];

   logic                      full, empty, found;
   logic [VALUE_WIDTH-1:0]    pick_value;
   logic [PRIORITY_WIDTH-1:0] pick_prio;

   logic [CW-1:0]             count_ff, count_in;
   status_type                status;

   logic                           rsp_strobe_ff;
   status_type                     rsp_status_ff;
   logic [VALUE_WIDTH-1:0]         rsp_removed_value_ff;
   logic [PRIO_PORT_WIDTH-1:0]     rsp_removed_prio_ff;
   logic [COUNT_PORT_WIDTH-1:0]    rsp_entry_count_ff;
   logic                           rsp_is_empty_ff;

   assign busy      = 1'b0;
   assign accept    = start && !busy;
   assign cmd       = command_type'(req_command);
   assign key_prio  = PRIORITY_WIDTH'(req_item_priority);
   assign key_value = req_item_value;

   assign full  = (count_ff == CW'(DEPTH));
   assign empty = (count_ff == '0);

   always_comb begin
      found = 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
         found = found | cell_eq[i];
      end
   end

   always_comb begin
      ctrl     = '0;
      status   = ST_OK;
      count_in = count_ff;
      if (accept) begin
         case (cmd)
            CMD_INSERT: begin
               if (full) begin
                  status = ST_FULL;
               end else begin
                  ctrl.insert = 1'b1;
                  count_in    = count_ff + CW'(1);
               end
            end
            CMD_TAKE_HEAD, CMD_TAKE_TAIL: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else begin
                  ctrl.take_head = (cmd == CMD_TAKE_HEAD);
                  ctrl.take_tail = (cmd == CMD_TAKE_TAIL);
                  count_in       = count_ff - CW'(1);
               end
            end
            CMD_TAKE_PRIO: begin
               if (empty) begin
                  status = ST_EMPTY;
               end else if (!found) begin
                  status = ST_NOT_FOUND;
               end else begin
                  ctrl.take_prio = 1'b1;
                  count_in       = count_ff - CW'(1);
               end
            end
            default: begin
               status = ST_OK;
            end
         endcase
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic                      l_valid, l_ge, l_eq, r_valid;
         logic [VALUE_WIDTH-1:0]    l_value, r_value;
         logic [PRIORITY_WIDTH-1:0] l_prio, r_prio;

         if (g == 0) begin : g_head
            // The head sees an always-higher, empty neighbor on its left.
            assign l_valid = 1'b0;
            assign l_ge    = 1'b1;
            assign l_eq    = 1'b0;
            assign l_value = '0;
            assign l_prio  = '0;
         end else begin : g_mid_l
            assign l_valid = cell_valid[g-1];
            assign l_ge    = cell_ge[g-1];
            assign l_eq    = cell_eq[g-1];
            assign l_value = cell_value[g-1];
            assign l_prio  = cell_prio[g-1];
         end

         if (g == DEPTH - 1) begin : g_tail
            assign r_valid = 1'b0;
            assign r_value = '0;
            assign r_prio  = '0;
         end else begin : g_mid_r
            assign r_valid = cell_valid[g+1];
            assign r_value = cell_value[g+1];
            assign r_prio  = cell_prio[g+1];
         end

         sdq_cell #(
            .PRIORITY_WIDTH(PRIORITY_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .key_value   (key_value),
            .key_prio    (key_prio),
            .left_valid  (l_valid),
            .left_ge     (l_ge),
            .left_eq     (l_eq),
            .left_value  (l_value),
            .left_prio   (l_prio),
            .right_valid (r_valid),
            .right_value (r_value),
            .right_prio  (r_prio),
            .valid       (cell_valid[g]),
            .value       (cell_value[g]),
            .prio        (cell_prio[g]),
            .ge          (cell_ge[g]),
            .eq          (cell_eq[g]),
            .sel         (cell_sel[g])
         );
      end
   endgenerate

   // At most one cell is selected, and none unless an entry leaves.
   always_comb begin
      pick_value = '0;
      pick_prio  = '0;
      for (int i = 0; i < DEPTH; i++) begin
         pick_value = pick_value | (cell_sel[i] ? cell_value[i] : '0);
         pick_prio  = pick_prio  | (cell_sel[i] ? cell_prio[i]  : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         rsp_strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_status_ff        <= status;
         rsp_removed_value_ff <= pick_value;
         rsp_removed_prio_ff  <= PRIO_PORT_WIDTH'(pick_prio);
         rsp_entry_count_ff   <= COUNT_PORT_WIDTH'(count_in);
         rsp_is_empty_ff      <= (count_in == '0);
      end
   end

   assign rsp_strobe           = rsp_strobe_ff;
   assign rsp_status           = rsp_status_ff;
   assign rsp_removed_value    = rsp_removed_value_ff;
   assign rsp_removed_priority = rsp_removed_prio_ff;
   assign rsp_entry_count      = rsp_entry_count_ff;
   assign rsp_is_empty         = rsp_is_empty_ff;

endmodule

// ===== rtl/sdq_cell.sv =====
// ----------------------------------------------------------------------------
// sdq_cell
// One slot of the sorted chain: holds an entry, compares it against the key
// of the current transaction and loads itself from the key, its left
// neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module sdq_cell #(
   parameter int PRIORITY_WIDTH = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  sdq_pkg::cell_ctrl_type            ctrl,
   input  logic [sdq_pkg::VALUE_WIDTH-1:0]   key_value,
   input  logic [PRIORITY_WIDTH-1:0]         key_prio,
   input  logic                              left_valid,
   input  logic                              left_ge,
   input  logic                              left_eq,
   input  logic [sdq_pkg::VALUE_WIDTH-1:0]   left_value,
   input  logic [PRIORITY_WIDTH-1:0]         left_prio,
   input  logic                              right_valid,
   input  logic [sdq_pkg::VALUE_WIDTH-1:0]   right_value,
   input  logic [PRIORITY_WIDTH-1:0]         right_prio,
   output logic                              valid,
   output logic [sdq_pkg::VALUE_WIDTH-1:0]   value,
   output logic [PRIORITY_WIDTH-1:0]         prio,
   output logic                              ge,
   output logic                              eq,
   output logic                              sel
);
   import sdq_pkg::*;

   logic                      valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0]    value_ff, value_in;
   logic [PRIORITY_WIDTH-1:0] prio_ff, prio_in;
   logic                      gt;

   assign ge = valid_ff && (prio_ff >= key_prio);
   assign eq = valid_ff && (prio_ff == key_prio);
   assign gt = ge && !eq;

   // Entries are contiguous from the head, so the ends are found locally.
   assign sel = (ctrl.take_head && valid_ff && !left_valid) ||
                (ctrl.take_tail && valid_ff && !right_valid) ||
                (ctrl.take_prio && eq && !left_eq);

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      prio_in  = prio_ff;
      if (ctrl.insert && !ge) begin
         if (left_ge) begin
            valid_in = 1'b1;
            value_in = key_value;
            prio_in  = key_prio;
         end else begin
            valid_in = left_valid;
            value_in = left_value;
            prio_in  = left_prio;
         end
      end else if (ctrl.take_head || (ctrl.take_prio && !gt)) begin
         valid_in = right_valid;
         value_in = right_value;
         prio_in  = right_prio;
      end else if (ctrl.take_tail) begin
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      prio_ff  <= prio_in;
   end

   assign valid = valid_ff;
   assign value = value_ff;
   assign prio  = prio_ff;

endmodule

// ===== rtl/sdq_checker.sv =====
// ----------------------------------------------------------------------------
// sdq_checker
// Port-level checks on the sorted priority deque, bound to its top level.
// ----------------------------------------------------------------------------
module sdq_checker (
   input logic                                  clock,
   input logic                                  reset,
   input logic                                  start,
   input logic                                  busy,
   input logic [1:0]                            req_command,
   input logic signed [sdq_pkg::VALUE_WIDTH-1:0] req_item_value,
   input logic [sdq_pkg::PRIO_PORT_WIDTH-1:0]   req_item_priority,
   input logic                                  rsp_strobe,
   input logic [1:0]                            rsp_status,
   input logic signed [sdq_pkg::VALUE_WIDTH-1:0] rsp_removed_value,
   input logic [sdq_pkg::PRIO_PORT_WIDTH-1:0]   rsp_removed_priority,
   input logic [sdq_pkg::COUNT_PORT_WIDTH-1:0]  rsp_entry_count,
   input logic                                  rsp_is_empty
);
   import sdq_pkg::*;

   // every accepted transaction answers exactly once, on the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe == $past(start && !busy))
      else $error("result strobe does not follow accepted transaction");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_is_empty) |-> (rsp_entry_count == '0))
      else $error("empty flag with nonzero count");

   a_no_removal: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != ST_OK || $past(req_command) == CMD_INSERT))
      |-> (rsp_removed_value == '0 && rsp_removed_priority == '0))
      else $error("removed fields set without a removal");

   a_full_on_insert: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_FULL) |-> ($past(req_command) == CMD_INSERT))
      else $error("full status on a removal");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == ST_EMPTY)
      |-> (rsp_is_empty && $past(req_command) != CMD_INSERT))
      else $error("empty status with entries held or on insert");

endmodule

bind sorted_priority_deque sdq_checker u_sdq_checker (.*);

// ===== tb/sorted_priority_deque_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_deque_tb
// Self-checking bench for the sorted priority deque. A short directed table
// covers empty, full and not-found cases and the value and priority extremes;
// random fill/drain bursts follow. Every transaction is checked field by
// field against a behavioral copy of the sorted queue or a hand-typed expectation.
// ----------------------------------------------------------------------------
module sorted_priority_deque_tb;
   import sdq_pkg::*;

   localparam int DEPTH       = 16;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] value;
      logic [7:0]         prio;
      logic [4:0]         count;
      logic               empty;
   } deque_result_type;

   typedef struct {
      command_type      cmd;
      logic [31:0]      val;
      logic [7:0]       pri;
      int               reps;
      logic             pinned;
      deque_result_type want;
   } stim_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = CMD_INSERT;
   logic signed [31:0] req_item_value = '0;
   logic [7:0]         req_item_priority = '0;
   logic               rsp_strobe;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_removed_value;
   logic [7:0]         rsp_removed_priority;
   logic [4:0]         rsp_entry_count;
   logic               rsp_is_empty;

   // hand-typed expectation that travels with the current transaction
   logic               pin_valid = 1'b0;
   deque_result_type   pin_result = '0;

   // behavioral copy of the queue, slot 0 is the head
   logic signed [31:0] sorted_val[DEPTH];
   logic [7:0]         sorted_prio[DEPTH];
   int                 held = 0;

   deque_result_type   pending_results[$];
   deque_result_type   got, want_now, predicted;
   stim_row_type       stim_rows[$];
   int                 mismatches = 0;
   int                 cycles = 0;

   sorted_priority_deque #(
      .DEPTH          (DEPTH),
      .PRIORITY_WIDTH (8)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_command          (req_command),
      .req_item_value       (req_item_value),
      .req_item_priority    (req_item_priority),
      .rsp_strobe           (rsp_strobe),
      .rsp_status           (rsp_status),
      .rsp_removed_value    (rsp_removed_value),
      .rsp_removed_priority (rsp_removed_priority),
      .rsp_entry_count      (rsp_entry_count),
      .rsp_is_empty         (rsp_is_empty)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Applies one command to the queue copy and returns what the block must report.
   function automatic deque_result_type deque_apply(command_type cmd,
                                                    logic signed [31:0] val,
                                                    logic [7:0] pri);
      deque_result_type r;
      int pos;
      int i;
      r.status = ST_OK;
      r.value  = '0;
      r.prio   = '0;
      if (cmd == CMD_INSERT) begin
         if (held >= DEPTH) begin
            r.status = ST_FULL;
         end else begin
            pos = 0;
            // equal priorities go behind the ones already held
            while (pos < held && sorted_prio[pos] >= pri) pos++;
            for (i = held; i > pos; i--) begin
               sorted_val[i]  = sorted_val[i-1];
               sorted_prio[i] = sorted_prio[i-1];
            end
            sorted_val[pos]  = val;
            sorted_prio[pos] = pri;
            held++;
         end
      end else if (held == 0) begin
         r.status = ST_EMPTY;
      end else begin
         pos = -1;
         if (cmd == CMD_TAKE_HEAD) pos = 0;
         else if (cmd == CMD_TAKE_TAIL) pos = held - 1;
         else begin
            for (i = 0; i < held; i++) begin
               if (pos < 0 && sorted_prio[i] == pri) pos = i;
            end
         end
         if (pos < 0) begin
            r.status = ST_NOT_FOUND;
         end else begin
            r.value = sorted_val[pos];
            r.prio  = sorted_prio[pos];
            for (i = pos; i + 1 < held; i++) begin
               sorted_val[i]  = sorted_val[i+1];
               sorted_prio[i] = sorted_prio[i+1];
            end
            held--;
         end
      end
      r.count = held[4:0];
      r.empty = (held == 0);
      return r;
   endfunction

   // Monitor: check results, then predict for the transaction accepted at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            got.status = status_type'(rsp_status);
            got.value  = rsp_removed_value;
            got.prio   = rsp_removed_priority;
            got.count  = rsp_entry_count;
            got.empty  = rsp_is_empty;
            if (pending_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: st=%0d val=%h pri=%0d cnt=%0d emp=%0b",
                           got.status, got.value, got.prio, got.count, got.empty);
            end else begin
               want_now = pending_results.pop_front();
               if (got !== want_now) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch: exp st=%0d val=%h pri=%0d cnt=%0d emp=%0b",
                               " | got st=%0d val=%h pri=%0d cnt=%0d emp=%0b"},
                              want_now.status, want_now.value, want_now.prio,
                              want_now.count, want_now.empty, got.status, got.value,
                              got.prio, got.count, got.empty);
               end
            end
         end
         if (start && !busy) begin
            predicted = deque_apply(command_type'(req_command), req_item_value,
                                    req_item_priority);
            pending_results.push_back(pin_valid ? pin_result : predicted);
         end
      end
   end

   function automatic void row(command_type cmd, logic [31:0] val, logic [7:0] pri, int reps,
                               logic pinned, status_type st, logic [31:0] rv,
                               logic [7:0] rp, logic [4:0] cnt, logic emp);
      stim_row_type s;
      s.cmd         = cmd;
      s.val         = val;
      s.pri         = pri;
      s.reps        = reps;
      s.pinned      = pinned;
      s.want.status = st;
      s.want.value  = rv;
      s.want.prio   = rp;
      s.want.count  = cnt;
      s.want.empty  = emp;
      stim_rows.push_back(s);
   endfunction

   // Drives one transaction after a random idle gap and waits until it is taken.
   task automatic send(command_type cmd, logic [31:0] val, logic [7:0] pri, int gap_pct,
                       logic pinned, deque_result_type want);
      while ($urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_command       <= cmd;
      req_item_value    <= val;
      req_item_priority <= pri;
      pin_valid         <= pinned;
      pin_result        <= want;
      @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // Fill/drain bursts so the queue regularly runs full and empty.
   task automatic random_traffic(int n, int gap_pct);
      deque_result_type none;
      command_type      cmd;
      logic [7:0]       pri;
      logic [31:0]      val;
      int               bias;
      none = '0;
      bias = 50;
      for (int k = 0; k < n; k++) begin
         if (k % 40 == 0) begin
            case ($urandom_range(2))
               0:       bias = 75;
               1:       bias = 30;
               default: bias = 50;
            endcase
         end
         if ($urandom_range(99) < bias) cmd = CMD_INSERT;
         else begin
            case ($urandom_range(2))
               0:       cmd = CMD_TAKE_HEAD;
               1:       cmd = CMD_TAKE_TAIL;
               default: cmd = CMD_TAKE_PRIO;
            endcase
         end
         case ($urandom_range(3))
            0:       pri = 8'($urandom_range(255));
            1:       pri = 8'($urandom_range(7));
            2:       pri = 8'hF8 | 8'($urandom_range(7));
            default: pri = (held > 0) ? sorted_prio[$urandom_range(held - 1)]
                                      : 8'($urandom_range(255));
         endcase
         val = $urandom;
         send(cmd, val, pri, gap_pct, 1'b0, none);
      end
   endtask

   initial begin
      int waited;
      waited = 0;
      //  command        value          prio  reps pin  status        rm value       rm prio cnt emp
      row(CMD_TAKE_HEAD, 32'h0,         8'd0,   1, 1, ST_EMPTY,     32'h0,         8'd0,   0, 1);
      row(CMD_TAKE_TAIL, 32'h5555_5555, 8'hFF,  1, 1, ST_EMPTY,     32'h0,         8'd0,   0, 1);
      row(CMD_TAKE_PRIO, 32'h0,         8'd0,   1, 1, ST_EMPTY,     32'h0,         8'd0,   0, 1);
      row(CMD_INSERT,    32'h7FFF_FFFF, 8'hFF,  1, 1, ST_OK,        32'h0,         8'd0,   1, 0);
      row(CMD_INSERT,    32'h8000_0000, 8'd0,   1, 1, ST_OK,        32'h0,         8'd0,   2, 0);
      row(CMD_TAKE_PRIO, 32'h0,         8'd7,   1, 1, ST_NOT_FOUND, 32'h0,         8'd0,   2, 0);
      row(CMD_TAKE_HEAD, 32'h0,         8'd0,   1, 1, ST_OK,        32'h7FFF_FFFF, 8'hFF,  1, 0);
      // single entry left, of another priority
      row(CMD_TAKE_PRIO, 32'h0,         8'h80,  1, 1, ST_NOT_FOUND, 32'h0,         8'd0,   1, 0);
      row(CMD_TAKE_TAIL, 32'h0,         8'd0,   1, 1, ST_OK,        32'h8000_0000, 8'd0,   0, 1);
      row(CMD_INSERT,    32'd100,       8'd10,  5, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_INSERT,    32'd200,       8'd200, 5, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_INSERT,    32'hFFFF_FFF9, 8'd10,  3, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_INSERT,    32'd300,       8'd0,   3, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_INSERT,    32'hAAAA_AAAA, 8'h55,  1, 1, ST_FULL,      32'h0,         8'd0,  16, 0);
      row(CMD_TAKE_PRIO, 32'h0,         8'd10,  1, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_TAKE_HEAD, 32'h0,         8'd0,   1, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_TAKE_TAIL, 32'h0,         8'd0,   1, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_TAKE_PRIO, 32'h0,         8'd200, 1, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_TAKE_PRIO, 32'h0,         8'd0,   1, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_INSERT,    32'h0,         8'd10,  1, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      row(CMD_TAKE_PRIO, 32'h0,         8'd10,  1, 0, ST_OK,        32'h0,         8'd0,   0, 0);
      // drain past empty
      row(CMD_TAKE_TAIL, 32'h0,         8'd0,  14, 0, ST_OK,        32'h0,         8'd0,   0, 0);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_rows[r]) begin
         for (int k = 0; k < stim_rows[r].reps; k++)
            send(stim_rows[r].cmd, stim_rows[r].val + 32'(k), stim_rows[r].pri, 12,
                 stim_rows[r].pinned, stim_rows[r].want);
      end

      random_traffic(350, 12);
      random_traffic(350, 62);
      random_traffic(350, 0);
      start     <= 1'b0;
      pin_valid <= 1'b0;

      while (pending_results.size() > 0 && waited < 1000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
